@@ hdl/lfp_pkg.sv @@
// Shared definitions for the LRU frame pool: sizes, operation and status codes,
// list codes, queue command and result types, and the sequencer states.
// No dependencies; every other file of the block uses this package.
package lfp_pkg;

    localparam int FRAMES      = 16;
    localparam int BLOCK_BYTES = 4096;

    localparam int IDX_W   = $clog2(FRAMES);
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int OFF_W   = $clog2(BLOCK_BYTES);
    localparam int OP_W    = 3;
    localparam int FRAME_W = 4;
    localparam int LEN_W   = 16;
    localparam int STS_W   = 3;
    localparam int SUM_W   = LEN_W + 1;
    localparam int IN_W    = 56;
    localparam int OUT_W   = 16;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [OP_W-1:0]    t_op;
    typedef logic [STS_W-1:0]   t_sts;
    typedef logic [1:0]         t_list;
    typedef logic [FRAME_W-1:0] t_frame;

    localparam t_op OP_ALLOC  = 3'd0;
    localparam t_op OP_TOUCH  = 3'd1;
    localparam t_op OP_LOCK   = 3'd2;
    localparam t_op OP_UNLOCK = 3'd3;
    localparam t_op OP_FREE   = 3'd4;
    localparam t_op OP_WRITE  = 3'd5;

    localparam t_sts STS_OK         = 3'd0;
    localparam t_sts STS_NO_FRAME   = 3'd1;
    localparam t_sts STS_LOCKED     = 3'd2;
    localparam t_sts STS_RANGE      = 3'd3;
    localparam t_sts STS_WRONG_LIST = 3'd4;

    localparam t_list LIST_FREE     = 2'd0;
    localparam t_list LIST_OCCUPIED = 2'd1;
    localparam t_list LIST_LOCKED   = 2'd2;

    typedef struct packed {
        logic remove;
        t_idx pos;
        logic push;
        t_idx val;
    } t_qcmd;

    // Packed so that ok lands in bit 0 of the output word.
    typedef struct packed {
        t_frame wb_frame;
        logic   write_back;
        t_frame granted;
        t_sts   status;
        logic   ok;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC
    } t_state;

endpackage

@@ hdl/lfp_cell.sv @@
// One cell of a queue chain: holds one frame index and takes its right
// neighbour's entry on a shift or a new entry on a push. Uses lfp_pkg.
module lfp_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lfp_pkg::t_idx i_rst_val,
    input  lfp_pkg::t_idx i_right,
    input  lfp_pkg::t_idx i_push_val,
    input  lfp_pkg::t_idx i_key,
    input  logic          i_shift,
    input  logic          i_push,
    output lfp_pkg::t_idx o_val,
    output logic          o_eq
);

    lfp_pkg::t_idx r_val;
    lfp_pkg::t_idx n_val;

    always_comb begin
        priority if (i_push) begin
            n_val = i_push_val;
        end else if (i_shift) begin
            n_val = i_right;
        end else begin
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= i_rst_val;
        end else begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;
    assign o_eq  = (r_val == i_key);

endmodule

@@ hdl/lfp_queue.sv @@
// Ordered frame queue built as a row of lfp_cell instances with a fill count;
// supports removal at any position with compaction and a push at the tail.
// Uses lfp_pkg and lfp_cell.
module lfp_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_full_at_reset,
    input  logic                       i_go,
    input  lfp_pkg::t_qcmd             i_cmd,
    input  lfp_pkg::t_idx              i_key,
    output lfp_pkg::t_idx              o_head,
    output lfp_pkg::t_cnt              o_cnt,
    output logic [lfp_pkg::FRAMES-1:0] o_match
);

    lfp_pkg::t_idx              w_val   [lfp_pkg::FRAMES];
    lfp_pkg::t_idx              w_right [lfp_pkg::FRAMES];
    logic [lfp_pkg::FRAMES-1:0] w_eq;
    lfp_pkg::t_cnt              r_cnt;
    lfp_pkg::t_cnt              n_cnt;
    lfp_pkg::t_cnt              w_push_idx;
    logic                       w_push_ok;

    assign w_push_idx = r_cnt - lfp_pkg::t_cnt'(i_cmd.remove);
    assign w_push_ok  = i_cmd.push && (w_push_idx < lfp_pkg::t_cnt'(lfp_pkg::FRAMES));

    always_comb begin
        if (i_go) begin
            n_cnt = w_push_idx + lfp_pkg::t_cnt'(w_push_ok);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= i_full_at_reset ? lfp_pkg::t_cnt'(lfp_pkg::FRAMES) : '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    for (genvar g = 0; g < lfp_pkg::FRAMES; g++) begin : g_cell
        localparam lfp_pkg::t_cnt CI = lfp_pkg::t_cnt'(g);

        if (g == lfp_pkg::FRAMES - 1) begin : g_last
            assign w_right[g] = w_val[g];
        end else begin : g_mid
            assign w_right[g] = w_val[g+1];
        end

        lfp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_rst_val  (lfp_pkg::t_idx'(g)),
            .i_right    (w_right[g]),
            .i_push_val (i_cmd.val),
            .i_key      (i_key),
            .i_shift    (i_go && i_cmd.remove && (lfp_pkg::t_cnt'(i_cmd.pos) <= CI)
                         && ((CI + lfp_pkg::t_cnt'(1)) < r_cnt)),
            .i_push     (i_go && w_push_ok && (w_push_idx == CI)),
            .o_val      (w_val[g]),
            .o_eq       (w_eq[g])
        );

        assign o_match[g] = w_eq[g] && (CI < r_cnt);
    end

    assign o_head = w_val[0];
    assign o_cnt  = r_cnt;

endmodule

@@ hdl/lru_frame_pool_with_pinning.sv @@
// Top level of the LRU frame pool with pinning: sequencer, frame list and
// dirty marks, and the free and recency queues. Uses lfp_pkg and lfp_queue.
//
// From acceptance to its result standing in the output register, a transaction
// is first captured in S_IDLE, then in S_LOOK the recency cell row is searched
// for the frame and the outcome is decided, and then in S_EXEC both cell chains
// shift or load and the frame list and dirty marks are written.
// One transaction is in work at a time; s_axis_tready is high while the block
// waits for the next one, also while an earlier result waits to be taken, and
// the chain update stalls only when that result has still not been taken.
// Reset makes every frame free at once, with frames 0 upwards queued in order.
module lru_frame_pool_with_pinning (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // opcode[2:0], frame[6:3], write_back_on_free[7], byte_offset[19:8], length[55:40]
    input  logic [lfp_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // ok[0], status[3:1], granted_frame[7:4], write_back[8], write_back_frame[12:9]
    output logic [lfp_pkg::OUT_W-1:0]  m_axis_tdata
);

    lfp_pkg::t_state r_state;
    lfp_pkg::t_state n_state;
    logic            w_in_ready;
    logic            w_go;
    logic            w_accept;

    lfp_pkg::t_op            r_op;
    lfp_pkg::t_frame         r_frame;
    logic                    r_wbo;
    logic [lfp_pkg::OFF_W-1:0] r_off;
    logic [lfp_pkg::LEN_W-1:0] r_len;

    lfp_pkg::t_list r_list  [lfp_pkg::FRAMES];
    logic           r_dirty [lfp_pkg::FRAMES];

    lfp_pkg::t_idx              w_free_head;
    lfp_pkg::t_cnt              w_free_cnt;
    logic [lfp_pkg::FRAMES-1:0] w_free_match;
    lfp_pkg::t_idx              w_rec_head;
    lfp_pkg::t_cnt              w_rec_cnt;
    logic [lfp_pkg::FRAMES-1:0] w_rec_match;
    lfp_pkg::t_idx              w_rec_pos;

    lfp_pkg::t_idx  w_fi;
    lfp_pkg::t_idx  w_dirty_addr;
    lfp_pkg::t_list w_lst;
    logic           w_dty;
    logic [lfp_pkg::SUM_W-1:0] w_end;

    lfp_pkg::t_result d_res;
    lfp_pkg::t_qcmd   d_free_cmd;
    lfp_pkg::t_qcmd   d_rec_cmd;
    logic             d_list_we;
    lfp_pkg::t_idx    d_list_idx;
    lfp_pkg::t_list   d_list_val;
    logic             d_dirty_we;
    lfp_pkg::t_idx    d_dirty_idx;
    logic             d_dirty_val;

    lfp_pkg::t_result r_res;
    lfp_pkg::t_qcmd   r_free_cmd;
    lfp_pkg::t_qcmd   r_rec_cmd;
    logic             r_list_we;
    lfp_pkg::t_idx    r_list_idx;
    lfp_pkg::t_list   r_list_val;
    logic             r_dirty_we;
    lfp_pkg::t_idx    r_dirty_idx;
    logic             r_dirty_val;

    logic             r_out_valid;
    logic             n_out_valid;
    lfp_pkg::t_result r_out;

    assign w_accept = s_axis_tvalid && w_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfp_pkg::S_IDLE: if (w_accept) begin
                n_state = lfp_pkg::S_LOOK;
            end
            lfp_pkg::S_LOOK: n_state = lfp_pkg::S_EXEC;
            lfp_pkg::S_EXEC: if (w_go) begin
                n_state = lfp_pkg::S_IDLE;
            end
            default: n_state = lfp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_go       = 1'b0;
        unique case (r_state)
            lfp_pkg::S_IDLE: w_in_ready = 1'b1;
            lfp_pkg::S_LOOK: w_go = 1'b0;
            lfp_pkg::S_EXEC: w_go = !r_out_valid || m_axis_tready;
            default: w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= s_axis_tdata[2:0];
            r_frame <= s_axis_tdata[6:3];
            r_wbo   <= s_axis_tdata[7];
            r_off   <= s_axis_tdata[8 +: lfp_pkg::OFF_W];
            r_len   <= s_axis_tdata[55:40];
        end
    end

    lfp_queue u_free_q (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_full_at_reset (1'b1),
        .i_go            (w_go),
        .i_cmd           (r_free_cmd),
        .i_key           (w_fi),
        .o_head          (w_free_head),
        .o_cnt           (w_free_cnt),
        .o_match         (w_free_match)
    );

    lfp_queue u_rec_q (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_full_at_reset (1'b0),
        .i_go            (w_go),
        .i_cmd           (r_rec_cmd),
        .i_key           (w_fi),
        .o_head          (w_rec_head),
        .o_cnt           (w_rec_cnt),
        .o_match         (w_rec_match)
    );

    always_comb begin
        w_rec_pos = '0;
        for (int i = 0; i < lfp_pkg::FRAMES; i++) begin
            if (w_rec_match[i]) begin
                w_rec_pos = w_rec_pos | lfp_pkg::t_idx'(i);
            end
        end
    end

    assign w_fi         = lfp_pkg::t_idx'(r_frame);
    assign w_dirty_addr = (r_op == lfp_pkg::OP_ALLOC) ? w_rec_head : w_fi;
    assign w_lst        = r_list[w_fi];
    assign w_dty        = r_dirty[w_dirty_addr];
    assign w_end        = lfp_pkg::SUM_W'(r_off) + lfp_pkg::SUM_W'(r_len);

    always_comb begin
        d_res       = '0;
        d_free_cmd  = '0;
        d_rec_cmd   = '0;
        d_list_we   = 1'b0;
        d_list_idx  = w_fi;
        d_list_val  = lfp_pkg::LIST_FREE;
        d_dirty_we  = 1'b0;
        d_dirty_idx = w_fi;
        d_dirty_val = 1'b0;
        d_free_cmd.val = w_fi;
        d_rec_cmd.val  = w_fi;
        d_rec_cmd.pos  = w_rec_pos;

        if (r_op == lfp_pkg::OP_ALLOC) begin
            if (w_free_cnt != '0) begin
                d_free_cmd.remove = 1'b1;
                d_free_cmd.pos    = '0;
                d_rec_cmd.push    = 1'b1;
                d_rec_cmd.val     = w_free_head;
                d_list_we         = 1'b1;
                d_list_idx        = w_free_head;
                d_list_val        = lfp_pkg::LIST_OCCUPIED;
                d_res.ok          = 1'b1;
                d_res.granted     = lfp_pkg::t_frame'(w_free_head);
            end else if (w_rec_cnt != '0) begin
                d_res.write_back  = w_dty;
                d_res.wb_frame    = w_dty ? lfp_pkg::t_frame'(w_rec_head) : '0;
                d_dirty_we        = 1'b1;
                d_dirty_idx       = w_rec_head;
                d_rec_cmd.remove  = 1'b1;
                d_rec_cmd.pos     = '0;
                d_rec_cmd.push    = 1'b1;
                d_rec_cmd.val     = w_rec_head;
                d_res.ok          = 1'b1;
                d_res.granted     = lfp_pkg::t_frame'(w_rec_head);
            end else begin
                d_res.status = lfp_pkg::STS_NO_FRAME;
            end
        end else if (r_op > lfp_pkg::OP_WRITE) begin
            d_res.status = lfp_pkg::STS_WRONG_LIST;
        end else if (int'(r_frame) >= lfp_pkg::FRAMES) begin
            d_res.status = lfp_pkg::STS_NO_FRAME;
        end else begin
            unique case (r_op)
                lfp_pkg::OP_TOUCH: begin
                    if (w_lst == lfp_pkg::LIST_OCCUPIED) begin
                        d_rec_cmd.remove = 1'b1;
                        d_rec_cmd.push   = 1'b1;
                        d_res.ok         = 1'b1;
                    end else begin
                        d_res.status = lfp_pkg::STS_WRONG_LIST;
                    end
                end
                lfp_pkg::OP_LOCK: begin
                    if (w_lst == lfp_pkg::LIST_OCCUPIED) begin
                        d_rec_cmd.remove = 1'b1;
                        d_list_we        = 1'b1;
                        d_list_val       = lfp_pkg::LIST_LOCKED;
                        d_res.ok         = 1'b1;
                    end else begin
                        d_res.status = lfp_pkg::STS_WRONG_LIST;
                    end
                end
                lfp_pkg::OP_UNLOCK: begin
                    if (w_lst == lfp_pkg::LIST_LOCKED) begin
                        d_rec_cmd.push = 1'b1;
                        d_list_we      = 1'b1;
                        d_list_val     = lfp_pkg::LIST_OCCUPIED;
                        d_res.ok       = 1'b1;
                    end else begin
                        d_res.status = lfp_pkg::STS_WRONG_LIST;
                    end
                end
                lfp_pkg::OP_FREE: begin
                    if (w_lst != lfp_pkg::LIST_FREE) begin
                        d_res.write_back = w_dty && r_wbo;
                        d_res.wb_frame   = (w_dty && r_wbo) ? r_frame : '0;
                        d_rec_cmd.remove = (w_lst == lfp_pkg::LIST_OCCUPIED);
                        d_dirty_we       = 1'b1;
                        d_list_we        = 1'b1;
                        d_list_val       = lfp_pkg::LIST_FREE;
                        d_free_cmd.push  = 1'b1;
                    end
                    d_res.ok = 1'b1;
                end
                lfp_pkg::OP_WRITE: begin
                    priority if (w_lst == lfp_pkg::LIST_LOCKED) begin
                        d_res.status = lfp_pkg::STS_LOCKED;
                    end else if (w_end > lfp_pkg::SUM_W'(lfp_pkg::BLOCK_BYTES)) begin
                        d_res.status = lfp_pkg::STS_RANGE;
                    end else if (w_lst != lfp_pkg::LIST_OCCUPIED) begin
                        d_res.status = lfp_pkg::STS_WRONG_LIST;
                    end else begin
                        d_dirty_we  = 1'b1;
                        d_dirty_val = 1'b1;
                        d_res.ok    = 1'b1;
                    end
                end
                default: d_res.status = lfp_pkg::STS_WRONG_LIST;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cmd <= '0;
            r_rec_cmd  <= '0;
            r_list_we  <= 1'b0;
            r_dirty_we <= 1'b0;
        end else if (r_state == lfp_pkg::S_LOOK) begin
            r_free_cmd <= d_free_cmd;
            r_rec_cmd  <= d_rec_cmd;
            r_list_we  <= d_list_we;
            r_dirty_we <= d_dirty_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lfp_pkg::S_LOOK) begin
            r_res       <= d_res;
            r_list_idx  <= d_list_idx;
            r_list_val  <= d_list_val;
            r_dirty_idx <= d_dirty_idx;
            r_dirty_val <= d_dirty_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lfp_pkg::FRAMES; i++) begin
                r_list[i]  <= lfp_pkg::LIST_FREE;
                r_dirty[i] <= 1'b0;
            end
        end else if (w_go) begin
            if (r_list_we) begin
                r_list[r_list_idx] <= r_list_val;
            end
            if (r_dirty_we) begin
                r_dirty[r_dirty_idx] <= r_dirty_val;
            end
        end
    end

    always_comb begin
        if (w_go) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !m_axis_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out <= r_res;
        end
    end

    assign s_axis_tready = w_in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(lfp_pkg::OUT_W - $bits(lfp_pkg::t_result))'(0), r_out};

endmodule

@@ hdl/lfp_checker.sv @@
// Port-level checker for the LRU frame pool, attached to the top level by the
// bind statement at the end of this file. Uses lfp_pkg.
module lfp_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [lfp_pkg::IN_W-1:0]  s_axis_tdata,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [lfp_pkg::OUT_W-1:0] m_axis_tdata
);

    // A result that is not taken stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or vanished");

    // Only one transaction is in work, so the input closes after an acceptance.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction accepted while one is in work");

    // The ok flag is set exactly when the status is ok.
    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == lfp_pkg::STS_OK)))
        else $error("ok flag disagrees with status");

    // A write-back is only reported by a successful transaction, and the frame
    // field is zero without one.
    a_wb_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[8] ? m_axis_tdata[0] : (m_axis_tdata[12:9] == 4'd0)))
        else $error("write-back report inconsistent");

    // Nothing is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered straight after reset");

endmodule

bind lru_frame_pool_with_pinning lfp_checker u_lfp_checker (.*);
